>>> rtl/core/srv_pkg.sv
// Shared constants, types and arithmetic helpers of the Schroeder reverberator.
package srv_pkg;

   // Build sizes
   localparam int NUM_COMB_LINES     = 4;
   localparam int NUM_ALLPASS_STAGES = 2;
   localparam int COMB_MAX_DEPTH     = 2048;
   localparam int ALLPASS_MAX_DEPTH  = 256;
   localparam int SAMPLE_WIDTH       = 16;

   // Register field widths and the register map
   localparam int GAIN_W      = 15;
   localparam int GAIN_FRAC   = 15;
   localparam int COMB_CFG_W  = 12;
   localparam int AP_CFG_W    = 9;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int COMB_SLOT_W = 2;
   localparam int AP_SLOT_W   = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_COMB_LENGTH_A     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COMB_LENGTH_B     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COMB_LENGTH_C     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COMB_LENGTH_D     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ALLPASS_LENGTH_A  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ALLPASS_LENGTH_B  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_COMB_GAIN         = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ALLPASS_GAIN      = 3'd7;

   localparam logic [COMB_CFG_W-1:0] COMB_LEN_RESET [8] = '{
      12'd1309, 12'd1636, 12'd1812, 12'd1927, 12'd2048, 12'd2048, 12'd2048, 12'd2048};
   localparam logic [AP_CFG_W-1:0] AP_LEN_RESET [4] = '{9'd220, 9'd74, 9'd256, 9'd256};
   localparam logic [GAIN_W-1:0] COMB_GAIN_RESET = 15'd26378;
   localparam logic [GAIN_W-1:0] AP_GAIN_RESET   = 15'd22938;

   // Output mix weights, Q0.15
   localparam logic [GAIN_W-1:0] DRY_MIX = 15'd9830;
   localparam logic [GAIN_W-1:0] WET_MIX = 15'd22938;

   // Derived widths
   localparam int COMB_SEL_W  = (NUM_COMB_LINES > 1) ? $clog2(NUM_COMB_LINES) : 1;
   localparam int AP_SEL_W    = (NUM_ALLPASS_STAGES > 1) ? $clog2(NUM_ALLPASS_STAGES) : 1;
   localparam int COMB_POS_W  = $clog2(COMB_MAX_DEPTH);
   localparam int COMB_LEN_W  = $clog2(COMB_MAX_DEPTH + 1);
   localparam int AP_POS_W    = $clog2(ALLPASS_MAX_DEPTH);
   localparam int AP_LEN_W    = $clog2(ALLPASS_MAX_DEPTH + 1);
   localparam int COMB_WORDS  = NUM_COMB_LINES * COMB_MAX_DEPTH;
   localparam int AP_WORDS    = NUM_ALLPASS_STAGES * ALLPASS_MAX_DEPTH;
   localparam int COMB_ADDR_W = $clog2(COMB_WORDS);
   localparam int AP_ADDR_W   = $clog2(AP_WORDS);
   localparam int CLR_WORDS   = (COMB_WORDS > AP_WORDS) ? COMB_WORDS : AP_WORDS;
   localparam int CLR_W       = $clog2(CLR_WORDS);
   localparam int CNT_W       = $clog2(NUM_COMB_LINES + 2);
   localparam int PROD_W      = SAMPLE_WIDTH + GAIN_W;
   localparam int RND_IN_W    = PROD_W + 1;
   localparam int RND_OUT_W   = RND_IN_W - GAIN_FRAC;
   localparam int SAT_IN_W    = SAMPLE_WIDTH + 2;
   localparam int SUM_W       = SAMPLE_WIDTH + COMB_SEL_W;
   localparam int ROUND_BIAS  = 1 << (GAIN_FRAC - 1);

   // Small queues between the sides
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [NUM_COMB_LINES-1:0][COMB_CFG_W-1:0]   comb_len;
      logic [NUM_ALLPASS_STAGES-1:0][AP_CFG_W-1:0] ap_len;
      logic [GAIN_W-1:0]                           comb_gain;
      logic [GAIN_W-1:0]                           ap_gain;
   } srv_cfg_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } srv_status_type;

   // Limit a comb length into 1..COMB_MAX_DEPTH
   function automatic logic [COMB_LEN_W-1:0] clamp_comb_len(input logic [COMB_CFG_W-1:0] len);
      logic [COMB_LEN_W-1:0] r;
      if (len == '0) r = COMB_LEN_W'(1);
      else if (32'(len) > 32'(COMB_MAX_DEPTH)) r = COMB_LEN_W'(COMB_MAX_DEPTH);
      else r = COMB_LEN_W'(len);
      return r;
   endfunction

   // Limit an allpass length into 1..ALLPASS_MAX_DEPTH
   function automatic logic [AP_LEN_W-1:0] clamp_ap_len(input logic [AP_CFG_W-1:0] len);
      logic [AP_LEN_W-1:0] r;
      if (len == '0) r = AP_LEN_W'(1);
      else if (32'(len) > 32'(ALLPASS_MAX_DEPTH)) r = AP_LEN_W'(ALLPASS_MAX_DEPTH);
      else r = AP_LEN_W'(len);
      return r;
   endfunction

   // Round a Q0.15-scaled product half up and drop the fraction
   function automatic logic signed [RND_OUT_W-1:0] round_q15(
      input logic signed [RND_IN_W-1:0] p);
      logic signed [RND_IN_W-1:0] t;
      t = p + RND_IN_W'(ROUND_BIAS);
      return $signed(t[RND_IN_W-1:GAIN_FRAC]);
   endfunction

   // Saturate into the signed sample range
   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [SAT_IN_W-1:0] v);
      logic signed [SAMPLE_WIDTH-1:0] r;
      if (!v[SAT_IN_W-1] && (|v[SAT_IN_W-2:SAMPLE_WIDTH-1]))
         r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      else if (v[SAT_IN_W-1] && !(&v[SAT_IN_W-2:SAMPLE_WIDTH-1]))
         r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      else
         r = v[SAMPLE_WIDTH-1:0];
      return r;
   endfunction

endpackage

>>> rtl/core/srv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/srv_fifo.sv
// Short sample queue used in front of and behind the processing sequencer.
module srv_fifo import srv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [SAMPLE_WIDTH-1:0] push_data,
   output logic                    full,
   input  logic                    pop,
   output logic [SAMPLE_WIDTH-1:0] pop_data,
   output logic                    empty
);

   logic [SAMPLE_WIDTH-1:0] data_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the beat in the entry at the write pointer
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/srv_csr.sv
// Configuration registers: delay lengths and gains.
module srv_csr import srv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output srv_cfg_type            cfg
);

   srv_cfg_type            cfg_ff, cfg_in;
   logic [COMB_SLOT_W-1:0] comb_slot;
   logic [AP_SLOT_W-1:0]   ap_slot;
   logic                   comb_hit, ap_hit;

   function automatic srv_cfg_type cfg_reset_value();
      srv_cfg_type r;
      for (int i = 0; i < NUM_COMB_LINES; i++) r.comb_len[i] = COMB_LEN_RESET[i];
      for (int i = 0; i < NUM_ALLPASS_STAGES; i++) r.ap_len[i] = AP_LEN_RESET[i];
      r.comb_gain = COMB_GAIN_RESET;
      r.ap_gain   = AP_GAIN_RESET;
      return r;
   endfunction

   // Decode the register index
   always_comb begin
      cfg_in    = cfg_ff;
      comb_slot = '0;
      ap_slot   = '0;
      comb_hit  = 1'b0;
      ap_hit    = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            REG_COMB_LENGTH_A: begin
               comb_hit  = 1'b1;
               comb_slot = 2'd0;
            end
            REG_COMB_LENGTH_B: begin
               comb_hit  = 1'b1;
               comb_slot = 2'd1;
            end
            REG_COMB_LENGTH_C: begin
               comb_hit  = 1'b1;
               comb_slot = 2'd2;
            end
            REG_COMB_LENGTH_D: begin
               comb_hit  = 1'b1;
               comb_slot = 2'd3;
            end
            REG_ALLPASS_LENGTH_A: begin
               ap_hit  = 1'b1;
               ap_slot = 1'd0;
            end
            REG_ALLPASS_LENGTH_B: begin
               ap_hit  = 1'b1;
               ap_slot = 1'd1;
            end
            REG_COMB_GAIN: cfg_in.comb_gain = csr_data[GAIN_W-1:0];
            REG_ALLPASS_GAIN: cfg_in.ap_gain = csr_data[GAIN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
      // Drop writes to lines that are not built
      if (comb_hit && (32'(comb_slot) < 32'(NUM_COMB_LINES))) begin
         cfg_in.comb_len[COMB_SEL_W'(comb_slot)] = csr_data[COMB_CFG_W-1:0];
      end
      if (ap_hit && (32'(ap_slot) < 32'(NUM_ALLPASS_STAGES))) begin
         cfg_in.ap_len[AP_SEL_W'(ap_slot)] = csr_data[AP_CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_reset_value();
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/srv_back.sv
// Processing sequencer: comb lines, allpass chain and dry/wet mix over two RAMs.
module srv_back import srv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  srv_cfg_type             cfg,
   input  logic                    in_empty,
   input  logic [SAMPLE_WIDTH-1:0] in_data,
   output logic                    in_pop,
   input  logic                    out_full,
   output logic                    out_push,
   output logic [SAMPLE_WIDTH-1:0] out_data,
   output srv_status_type          status
);

   typedef enum logic [10:0] {
      ST_CLEAR   = 11'b000_0000_0001,
      ST_IDLE    = 11'b000_0000_0010,
      ST_COMB    = 11'b000_0000_0100,
      ST_AP_RD   = 11'b000_0000_1000,
      ST_AP_MUL1 = 11'b000_0001_0000,
      ST_AP_WR   = 11'b000_0010_0000,
      ST_AP_MUL2 = 11'b000_0100_0000,
      ST_AP_OUT  = 11'b000_1000_0000,
      ST_MIX_DRY = 11'b001_0000_0000,
      ST_MIX_WET = 11'b010_0000_0000,
      ST_MIX_OUT = 11'b100_0000_0000
   } srv_state_type;

   srv_state_type state_ff, state_in;

   logic [CLR_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [AP_SEL_W-1:0]   stage_ff, stage_in;
   logic [COMB_POS_W-1:0] comb_pos_ff [NUM_COMB_LINES];
   logic [COMB_POS_W-1:0] comb_pos_in [NUM_COMB_LINES];
   logic [AP_POS_W-1:0]   ap_pos_ff [NUM_ALLPASS_STAGES];
   logic [AP_POS_W-1:0]   ap_pos_in [NUM_ALLPASS_STAGES];
   logic                  rv1_ff, rv1_in, rv2_ff, rv2_in;
   logic [COMB_ADDR_W-1:0] a1_ff, a1_in, a2_ff, a2_in;
   logic [AP_ADDR_W-1:0]   apa_ff, apa_in;

   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [SAMPLE_WIDTH-1:0] ap_ff, ap_in;
   logic signed [SAMPLE_WIDTH-1:0] buf_ff, buf_in;
   logic signed [SAMPLE_WIDTH-1:0] v_ff, v_in;
   logic signed [SAMPLE_WIDTH-1:0] dly_ff, dly_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [PROD_W-1:0]       dry_ff, dry_in;

   // RAM ports
   logic                    comb_we, ap_we;
   logic [COMB_ADDR_W-1:0]  comb_waddr, comb_raddr;
   logic [AP_ADDR_W-1:0]    ap_waddr, ap_raddr;
   logic [SAMPLE_WIDTH-1:0] comb_wdata, comb_rdata, ap_wdata, ap_rdata;

   // Position stepping
   logic [COMB_SEL_W-1:0] line;
   logic [COMB_LEN_W-1:0] comb_len_sel, comb_p1;
   logic [COMB_POS_W-1:0] comb_p, comb_pos_next;
   logic [AP_LEN_W-1:0]   ap_len_sel, ap_p1;
   logic [AP_POS_W-1:0]   ap_p, ap_pos_next;
   logic                  comb_issue;

   // Arithmetic
   logic signed [SAMPLE_WIDTH-1:0] mul_a;
   logic [GAIN_W-1:0]              mul_b;
   logic signed [PROD_W-1:0]       mul_a_ext, mul_b_ext;
   logic signed [RND_OUT_W-1:0]    rnd, mix_q;
   logic signed [RND_IN_W-1:0]     mix_sum;
   logic signed [SUM_W-1:0]        sum_acc, sum_avg;
   logic signed [SAMPLE_WIDTH-1:0] comb_sat, ap_v, ap_out, mix_y;

   srv_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(COMB_WORDS)) u_comb_ram (
      .clock   (clock),
      .wr_en   (comb_we),
      .wr_addr (comb_waddr),
      .wr_data (comb_wdata),
      .rd_addr (comb_raddr),
      .rd_data (comb_rdata)
   );

   srv_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(AP_WORDS)) u_ap_ram (
      .clock   (clock),
      .wr_en   (ap_we),
      .wr_addr (ap_waddr),
      .wr_data (ap_wdata),
      .rd_addr (ap_raddr),
      .rd_data (ap_rdata)
   );

   // Step the comb line position selected by the read counter
   always_comb begin
      line          = cnt_ff[COMB_SEL_W-1:0];
      comb_len_sel  = clamp_comb_len(cfg.comb_len[line]);
      comb_p        = (COMB_LEN_W'(comb_pos_ff[line]) >= comb_len_sel) ? '0 : comb_pos_ff[line];
      comb_p1       = COMB_LEN_W'(comb_p) + 1'b1;
      comb_pos_next = (comb_p1 >= comb_len_sel) ? '0 : comb_p1[COMB_POS_W-1:0];
      comb_raddr    = COMB_ADDR_W'(line) * COMB_ADDR_W'(COMB_MAX_DEPTH)
                    + COMB_ADDR_W'(comb_p);
      comb_issue    = (state_ff == ST_COMB) && (cnt_ff < CNT_W'(NUM_COMB_LINES));
   end

   // Step the position of the current allpass stage
   always_comb begin
      ap_len_sel  = clamp_ap_len(cfg.ap_len[stage_ff]);
      ap_p        = (AP_LEN_W'(ap_pos_ff[stage_ff]) >= ap_len_sel) ? '0 : ap_pos_ff[stage_ff];
      ap_p1       = AP_LEN_W'(ap_p) + 1'b1;
      ap_pos_next = (ap_p1 >= ap_len_sel) ? '0 : ap_p1[AP_POS_W-1:0];
      ap_raddr    = AP_ADDR_W'(stage_ff) * AP_ADDR_W'(ALLPASS_MAX_DEPTH) + AP_ADDR_W'(ap_p);
   end

   // Shared gain multiplier, operands chosen by state
   always_comb begin
      case (state_ff)
         ST_AP_MUL1: begin
            mul_a = $signed(ap_rdata);
            mul_b = cfg.ap_gain;
         end
         ST_AP_MUL2: begin
            mul_a = v_ff;
            mul_b = cfg.ap_gain;
         end
         ST_MIX_DRY: begin
            mul_a = x_ff;
            mul_b = DRY_MIX;
         end
         ST_MIX_WET: begin
            mul_a = ap_ff;
            mul_b = WET_MIX;
         end
         default: begin
            mul_a = $signed(comb_rdata);
            mul_b = cfg.comb_gain;
         end
      endcase
      mul_a_ext = PROD_W'(mul_a);
      mul_b_ext = $signed(PROD_W'({1'b0, mul_b}));
      prod_in   = mul_a_ext * mul_b_ext;
   end

   // Round the product and form the stored and passed values
   always_comb begin
      rnd      = round_q15(RND_IN_W'(prod_ff));
      comb_sat = sat_sample(SAT_IN_W'(x_ff) + SAT_IN_W'(rnd));
      ap_v     = sat_sample(SAT_IN_W'(ap_ff) + SAT_IN_W'(rnd));
      ap_out   = sat_sample(SAT_IN_W'(buf_ff) - SAT_IN_W'(rnd));
      sum_acc  = sum_ff + SUM_W'(dly_ff);
      sum_avg  = sum_acc >>> 2;
      mix_sum  = RND_IN_W'(dry_ff) + RND_IN_W'(prod_ff);
      mix_q    = round_q15(mix_sum);
      mix_y    = sat_sample(SAT_IN_W'(mix_q));
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      cnt_in      = cnt_ff;
      stage_in    = stage_ff;
      comb_pos_in = comb_pos_ff;
      ap_pos_in   = ap_pos_ff;
      rv1_in      = 1'b0;
      rv2_in      = 1'b0;
      a1_in       = comb_raddr;
      a2_in       = a1_ff;
      apa_in      = apa_ff;
      x_in        = x_ff;
      ap_in       = ap_ff;
      buf_in      = buf_ff;
      v_in        = v_ff;
      dly_in      = $signed(comb_rdata);
      sum_in      = sum_ff;
      dry_in      = dry_ff;
      in_pop      = 1'b0;
      out_push    = 1'b0;
      out_data    = mix_y;
      comb_we     = 1'b0;
      comb_waddr  = a2_ff;
      comb_wdata  = comb_sat;
      ap_we       = 1'b0;
      ap_waddr    = apa_ff;
      ap_wdata    = ap_v;

      case (state_ff)
         ST_CLEAR: begin
            // Zero both delay stores, one word a cycle
            comb_we    = (32'(clr_cnt_ff) < 32'(COMB_WORDS));
            comb_waddr = COMB_ADDR_W'(clr_cnt_ff);
            comb_wdata = '0;
            ap_we      = (32'(clr_cnt_ff) < 32'(AP_WORDS));
            ap_waddr   = AP_ADDR_W'(clr_cnt_ff);
            ap_wdata   = '0;
            if (clr_cnt_ff == CLR_W'(CLR_WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            // Start only with room for the result
            if (!in_empty && !out_full) begin
               in_pop   = 1'b1;
               x_in     = $signed(in_data);
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_COMB;
            end
         end

         ST_COMB: begin
            // Read, multiply, write back: one line enters each cycle
            rv1_in = comb_issue;
            rv2_in = rv1_ff;
            if (comb_issue) begin
               comb_pos_in[line] = comb_pos_next;
            end
            if (rv2_ff) begin
               comb_we = 1'b1;
               sum_in  = sum_acc;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_COMB_LINES + 1)) begin
               ap_in    = sat_sample(SAT_IN_W'(sum_avg));
               stage_in = '0;
               state_in = ST_AP_RD;
            end
         end

         ST_AP_RD: begin
            ap_pos_in[stage_ff] = ap_pos_next;
            apa_in              = ap_raddr;
            state_in            = ST_AP_MUL1;
         end

         ST_AP_MUL1: begin
            buf_in   = $signed(ap_rdata);
            state_in = ST_AP_WR;
         end

         ST_AP_WR: begin
            ap_we    = 1'b1;
            v_in     = ap_v;
            state_in = ST_AP_MUL2;
         end

         ST_AP_MUL2: begin
            state_in = ST_AP_OUT;
         end

         ST_AP_OUT: begin
            ap_in = ap_out;
            if (stage_ff == AP_SEL_W'(NUM_ALLPASS_STAGES - 1)) begin
               state_in = ST_MIX_DRY;
            end else begin
               stage_in = stage_ff + 1'b1;
               state_in = ST_AP_RD;
            end
         end

         ST_MIX_DRY: begin
            state_in = ST_MIX_WET;
         end

         ST_MIX_WET: begin
            dry_in   = prod_ff;
            state_in = ST_MIX_OUT;
         end

         ST_MIX_OUT: begin
            out_push = 1'b1;
            state_in = ST_IDLE;
         end

         default: state_in = ST_CLEAR;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_cnt_ff  <= '0;
         cnt_ff      <= '0;
         stage_ff    <= '0;
         rv1_ff      <= 1'b0;
         rv2_ff      <= 1'b0;
         for (int i = 0; i < NUM_COMB_LINES; i++) comb_pos_ff[i] <= '0;
         for (int i = 0; i < NUM_ALLPASS_STAGES; i++) ap_pos_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         cnt_ff      <= cnt_in;
         stage_ff    <= stage_in;
         rv1_ff      <= rv1_in;
         rv2_ff      <= rv2_in;
         comb_pos_ff <= comb_pos_in;
         ap_pos_ff   <= ap_pos_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      a1_ff   <= a1_in;
      a2_ff   <= a2_in;
      apa_ff  <= apa_in;
      x_ff    <= x_in;
      ap_ff   <= ap_in;
      buf_ff  <= buf_in;
      v_ff    <= v_in;
      dly_ff  <= dly_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      dry_ff  <= dry_in;
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.busy     = (state_ff != ST_CLEAR) && (state_ff != ST_IDLE);

endmodule

>>> rtl/core/schroeder_reverb.sv
// Schroeder reverberator top level: four comb lines, two allpass stages, dry/wet mix.
// Each sample passes through the accepting idle state, the comb pass, each allpass stage and the
// mix states, as the single sequencer steps through the comb RAM, the allpass RAM and one
// multiplier; no new sample is taken before the last one's result is pushed.
// Two-entry queues on both sides take new samples and hold results while the sequencer works.
// Reset: control and configuration registers return to their reset values, then a clearing pass
// zeroes the delay stores; req_full stays high during that pass.
module schroeder_reverb import srv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input  logic                    csr_write_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   srv_cfg_type             cfg;
   srv_status_type          back_status;
   logic                    front_full, front_empty, front_pop;
   logic [SAMPLE_WIDTH-1:0] front_data;
   logic                    resp_full, back_push;
   logic [SAMPLE_WIDTH-1:0] back_data;

   srv_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   // Hold off new beats while the delay stores are cleared
   assign req_full = front_full || back_status.clearing;

   srv_fifo u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !req_full),
      .push_data (req_sample_in),
      .full      (front_full),
      .pop       (front_pop),
      .pop_data  (front_data),
      .empty     (front_empty)
   );

   srv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_empty (front_empty),
      .in_data  (front_data),
      .in_pop   (front_pop),
      .out_full (resp_full),
      .out_push (back_push),
      .out_data (back_data),
      .status   (back_status)
   );

   srv_fifo u_resp (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_data),
      .full      (resp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_sample_out),
      .empty     (rsp_empty)
   );

   // No result appears and no sample is taken during the clearing pass
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> (rsp_empty && req_full))
      else $error("result or input beat during clearing pass");

   // The sequencer takes a sample only from a non-empty front queue
   a_pop_source: assert property (@(posedge clock) disable iff (reset)
      front_pop |-> !front_empty)
      else $error("sequencer popped an empty front queue");

   // A finished result always finds room in the result queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      back_push |-> !resp_full)
      else $error("result pushed into a full queue");

   // After delivering a result the sequencer is idle again
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      back_push |=> !back_status.busy)
      else $error("sequencer still busy after its result");

endmodule
